@@ src/psff_pkg.sv @@
// psff_pkg: types, character codes and small lookup functions for the
// streaming field formatter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psff_pkg;

    localparam int P_MAX_FIELD  = 63;
    localparam int P_MAX_STRING = 32;
    localparam int P_VALUE_BITS = 32;

    localparam int FW = 6;
    localparam int CW = 31;
    localparam logic [CW-1:0] COUNT_MAX = '1;
    localparam logic [2:0] NULL_LEN = 3'd6;

    localparam logic [2:0] MODE_FMT   = 3'd0;
    localparam logic [2:0] MODE_INT   = 3'd1;
    localparam logic [2:0] MODE_SBYTE = 3'd2;
    localparam logic [2:0] MODE_SEND  = 3'd3;
    localparam logic [2:0] MODE_SNULL = 3'd4;
    localparam logic [2:0] MODE_FEND  = 3'd5;

    localparam logic [7:0] C_PCT   = 8'h25;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_NINE  = 8'h39;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_S     = 8'h73;
    localparam logic [7:0] C_D     = 8'h64;
    localparam logic [7:0] C_X     = 8'h78;
    localparam logic [7:0] C_LA    = 8'h61;

    typedef enum logic [2:0] {
        PH_TEXT, PH_PCT, PH_WID, PH_PREC, PH_INT, PH_STR
    } t_phase;

    typedef enum logic [1:0] {
        CV_NONE, CV_S, CV_D, CV_X
    } t_conv;

    typedef enum logic [3:0] {
        S_IDLE, S_LIT, S_END, S_CONV, S_NSET, S_NEMIT,
        S_SSET, S_SPAD, S_SRD, S_SCHR
    } t_state;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = C_ZERO + 8'(d);
        end else begin
            c = C_LA + 8'(d) - 8'd10;
        end
        return c;
    endfunction

    function automatic logic [7:0] null_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h28;
            3'd1: c = 8'h6E;
            3'd2: c = 8'h75;
            3'd3: c = 8'h6C;
            3'd4: c = 8'h6C;
            3'd5: c = 8'h29;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/printf_sdx_field_formatter_top.sv @@
// printf_sdx_field_formatter_top: streaming printf-style formatter for s, d, x.
// Depends on psff_pkg.
//
// Usage: the format string enters one character per input transfer (mode 0),
// arguments as their own transfers (1 integer, 2 string byte, 3 string end,
// 4 null string) and mode 5 closes the format, giving the character count as
// a result with o_is_count set. Every result carries o_last on the final
// character produced by its input item; items producing nothing give no result.
// o_ready is high only while the sequencer is idle; one item is worked on at
// a time.
// Flow: a parse-only item is handled in the idle state. A literal character
// passes through the S_LIT state and the output register. A decimal argument
// is shifted through a shift/add-3 binary-to-BCD unit (S_CONV), then set up
// (S_NSET), then emitted one character per cycle while the receiver is ready.
// Hex skips the conversion. String bytes are read from the string memory with
// a registered port (S_SRD, then S_SCHR). A stalled receiver holds the output
// register and the sequencer waits; nothing is lost. Reset clears control
// state; the string memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module printf_sdx_field_formatter_top
    import psff_pkg::*;
#(
    parameter int MAX_FIELD  = P_MAX_FIELD,
    parameter int MAX_STRING = P_MAX_STRING,
    parameter int VALUE_BITS = P_VALUE_BITS
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire  [2:0]        i_mode,
    input  wire  [7:0]        i_char_in,
    input  wire  signed [31:0] i_value,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [7:0]        o_char_out,
    output logic              o_is_count,
    output logic [CW-1:0]     o_count,
    output logic              o_last
);

    localparam int VB  = VALUE_BITS;
    localparam int ND  = (VB * 3) / 10 + 1;
    localparam int BW  = 4 * ND;
    localparam int DLW = $clog2(ND + 1);
    localparam int DIW = $clog2(ND);
    localparam int SIW = $clog2(MAX_STRING);
    localparam int LW  = $clog2(MAX_STRING + 1);
    localparam int KW  = $clog2(VB);

    function automatic logic [FW-1:0] sat_field(input logic [FW-1:0] acc,
                                                input logic [3:0] d);
        logic [9:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {6'd0, d};
        return (v > 10'(MAX_FIELD)) ? FW'(MAX_FIELD) : v[FW-1:0];
    endfunction

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    t_conv           r_conv, n_conv;
    logic [FW-1:0]   r_width, n_width;
    logic [FW-1:0]   r_prec, n_prec;
    logic            r_prec_set, n_prec_set;
    logic            r_halted, n_halted;
    logic            r_pct, n_pct;
    logic [7:0]      r_ch, n_ch;
    logic [LW-1:0]   r_slen, n_slen;
    logic [LW-1:0]   r_sidx, n_sidx;
    logic            r_null, n_null;
    logic [VB-1:0]   r_mag, n_mag;
    logic            r_neg, n_neg;
    logic [BW-1:0]   r_bcd, n_bcd;
    logic [KW-1:0]   r_cnt, n_cnt;
    logic [FW-1:0]   r_nsp, n_nsp;
    logic [FW-1:0]   r_nz, n_nz;
    logic [DLW-1:0]  r_ndig, n_ndig;
    logic [7:0]      r_rem, n_rem;
    logic [CW-1:0]   r_total;
    logic [7:0]      r_rdata;
    logic [7:0]      r_mem [MAX_STRING];

    logic            r_ovalid;
    logic [7:0]      r_ochar;
    logic            r_ois_count;
    logic [CW-1:0]   r_ocount;
    logic            r_olast;

    logic            w_acc, w_free, w_emit, w_is_cnt, w_last, w_clr, w_we;
    logic [7:0]      w_char;
    logic            w_digit;
    logic [3:0]      w_dval;
    logic [VB-1:0]   w_bits;
    logic [BW-1:0]   w_adj;
    logic [DLW-1:0]  w_len;
    logic [DLW-1:0]  w_dm1;
    logic signed [7:0] w_wid, w_p, w_lens, w_top;
    logic [FW-1:0]   w_nsp, w_nz;
    logic [7:0]      w_ntot;
    logic [LW-1:0]   w_ssrc, w_slen_eff;
    logic [FW-1:0]   w_ssp;
    logic [7:0]      w_stot;

    assign o_ready    = (r_state == S_IDLE);
    assign w_acc      = i_valid && o_ready;
    assign w_free     = !r_ovalid || i_ready;
    assign o_valid    = r_ovalid;
    assign o_char_out = r_ochar;
    assign o_is_count = r_ois_count;
    assign o_count    = r_ocount;
    assign o_last     = r_olast;

    assign w_digit = (i_char_in >= C_ZERO) && (i_char_in <= C_NINE);
    assign w_dval  = 4'(i_char_in - C_ZERO);
    assign w_bits  = i_value[VB-1:0];
    assign w_dm1   = r_ndig - DLW'(1);
    assign w_we    = w_acc && !r_halted && (i_mode == MODE_SBYTE) && (r_phase == PH_STR)
                     && (i_char_in != 8'd0) && (r_slen < LW'(MAX_STRING));

    // number set-up: digit count and padding
    always_comb begin
        w_len = '0;
        for (int i = 0; i < ND; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                w_len = DLW'(i + 1);
            end
        end
        if (w_len == '0) begin
            w_len = (r_prec_set && r_prec == '0) ? DLW'(0) : DLW'(1);
        end
        w_wid  = 8'(r_width) - 8'(r_neg);
        w_p    = r_prec_set ? 8'(r_prec) : 8'hFF;
        w_lens = 8'(w_len);
        w_top  = (w_p > w_lens) ? w_p : w_lens;
        w_nsp  = (w_wid > w_top) ? FW'(w_wid - w_top) : '0;
        w_nz   = (w_p > w_lens) ? FW'(w_p - w_lens) : '0;
        w_ntot = 8'(w_nsp) + 8'(r_neg) + 8'(w_nz) + 8'(w_len);
    end

    // string set-up: truncation and padding
    always_comb begin
        w_ssrc = r_null ? LW'(NULL_LEN) : r_slen;
        if (r_prec_set && r_prec == '0) begin
            w_slen_eff = '0;
        end else if (r_prec_set && 8'(r_prec) < 8'(w_ssrc)) begin
            w_slen_eff = LW'(r_prec);
        end else begin
            w_slen_eff = w_ssrc;
        end
        w_ssp  = (8'(r_width) > 8'(w_slen_eff)) ? FW'(8'(r_width) - 8'(w_slen_eff)) : '0;
        w_stot = 8'(w_ssp) + 8'(w_slen_eff);
    end

    always_comb begin
        for (int i = 0; i < ND; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                         : r_bcd[4*i +: 4];
        end
    end

    // outputs of the sequencer
    always_comb begin
        w_emit   = 1'b0;
        w_char   = 8'd0;
        w_is_cnt = 1'b0;
        w_last   = 1'b0;
        unique case (r_state)
            S_LIT: begin
                w_emit = w_free;
                w_char = r_ch;
                w_last = 1'b1;
            end
            S_END: begin
                w_emit = w_free;
                if (r_pct) begin
                    w_char = C_PCT;
                end else begin
                    w_is_cnt = 1'b1;
                    w_last   = 1'b1;
                end
            end
            S_NEMIT: begin
                w_emit = w_free;
                w_last = (r_rem == 8'd1);
                if (r_nsp != '0) begin
                    w_char = C_SPACE;
                end else if (r_neg) begin
                    w_char = C_MINUS;
                end else if (r_nz != '0) begin
                    w_char = C_ZERO;
                end else begin
                    w_char = digit_char(r_bcd[4*w_dm1[DIW-1:0] +: 4]);
                end
            end
            S_SPAD: begin
                w_emit = w_free;
                w_char = C_SPACE;
                w_last = (r_rem == 8'd1);
            end
            S_SCHR: begin
                w_emit = w_free;
                w_char = r_null ? null_char(r_sidx[2:0]) : r_rdata;
                w_last = (r_rem == 8'd1);
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_mode == MODE_FEND) begin
                        n_state = S_END;
                    end else if (!r_halted) begin
                        case (i_mode)
                            MODE_FMT: begin
                                if (r_phase == PH_TEXT && i_char_in != C_PCT) begin
                                    n_state = S_LIT;
                                end
                            end
                            MODE_INT: begin
                                if (r_phase == PH_INT) begin
                                    n_state = (r_conv == CV_X) ? S_NSET : S_CONV;
                                end
                            end
                            MODE_SBYTE, MODE_SEND, MODE_SNULL: begin
                                if (r_phase == PH_STR &&
                                    !(i_mode == MODE_SBYTE && i_char_in != 8'd0)) begin
                                    n_state = S_SSET;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_LIT:   if (w_emit) n_state = S_IDLE;
            S_END:   if (w_emit && !r_pct) n_state = S_IDLE;
            S_CONV:  if (r_cnt == '0) n_state = S_NSET;
            S_NSET:  n_state = (w_ntot == 8'd0) ? S_IDLE : S_NEMIT;
            S_NEMIT: if (w_emit && w_last) n_state = S_IDLE;
            S_SSET: begin
                if (w_stot == 8'd0) begin
                    n_state = S_IDLE;
                end else if (w_ssp != '0) begin
                    n_state = S_SPAD;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SPAD: begin
                if (w_emit) begin
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else if (r_nsp == FW'(1)) begin
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD:   n_state = S_SCHR;
            S_SCHR: begin
                if (w_emit) begin
                    n_state = w_last ? S_IDLE : S_SRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_phase    = r_phase;
        n_conv     = r_conv;
        n_width    = r_width;
        n_prec     = r_prec;
        n_prec_set = r_prec_set;
        n_halted   = r_halted;
        n_pct      = r_pct;
        n_ch       = r_ch;
        n_slen     = r_slen;
        n_sidx     = r_sidx;
        n_null     = r_null;
        n_mag      = r_mag;
        n_neg      = r_neg;
        n_bcd      = r_bcd;
        n_cnt      = r_cnt;
        n_nsp      = r_nsp;
        n_nz       = r_nz;
        n_ndig     = r_ndig;
        n_rem      = r_rem;
        w_clr      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_ch = i_char_in;
                    if (i_mode == MODE_FEND) begin
                        n_pct = !r_halted && (r_phase == PH_PCT);
                    end else if (!r_halted) begin
                        case (i_mode)
                            MODE_FMT: begin
                                if (r_phase == PH_TEXT) begin
                                    if (i_char_in == C_PCT) begin
                                        n_phase    = PH_PCT;
                                        n_width    = '0;
                                        n_prec_set = 1'b0;
                                    end
                                end else if (r_phase == PH_PCT || r_phase == PH_WID ||
                                             r_phase == PH_PREC) begin
                                    if (w_digit && r_phase != PH_PREC) begin
                                        n_width = sat_field(r_width, w_dval);
                                        n_phase = PH_WID;
                                    end else if (w_digit) begin
                                        n_prec = sat_field(r_prec, w_dval);
                                    end else if (i_char_in == C_DOT && r_phase != PH_PREC) begin
                                        n_prec     = '0;
                                        n_prec_set = 1'b1;
                                        n_phase    = PH_PREC;
                                    end else if (i_char_in == C_S) begin
                                        n_conv  = CV_S;
                                        n_slen  = '0;
                                        n_phase = PH_STR;
                                    end else if (i_char_in == C_D || i_char_in == C_X) begin
                                        n_conv  = (i_char_in == C_D) ? CV_D : CV_X;
                                        n_phase = PH_INT;
                                    end else begin
                                        n_halted = 1'b1;
                                    end
                                end
                            end
                            MODE_INT: begin
                                if (r_phase == PH_INT) begin
                                    n_neg = (r_conv == CV_D) && w_bits[VB-1];
                                    n_mag = n_neg ? (~w_bits + VB'(1)) : w_bits;
                                    n_bcd = (r_conv == CV_X) ? {{(BW-VB){1'b0}}, w_bits}
                                                             : '0;
                                    n_cnt = KW'(VB - 1);
                                end
                            end
                            MODE_SBYTE, MODE_SEND, MODE_SNULL: begin
                                if (r_phase == PH_STR) begin
                                    if (i_mode == MODE_SBYTE && i_char_in != 8'd0) begin
                                        if (r_slen < LW'(MAX_STRING)) begin
                                            n_slen = r_slen + LW'(1);
                                        end
                                    end else begin
                                        n_null = (i_mode == MODE_SNULL);
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_CONV: begin
                n_bcd = {w_adj[BW-2:0], r_mag[VB-1]};
                n_mag = {r_mag[VB-2:0], 1'b0};
                n_cnt = r_cnt - KW'(1);
            end
            S_NSET: begin
                n_nsp  = w_nsp;
                n_nz   = w_nz;
                n_ndig = w_len;
                n_rem  = w_ntot;
                if (w_ntot == 8'd0) w_clr = 1'b1;
            end
            S_NEMIT: begin
                if (w_emit) begin
                    n_rem = r_rem - 8'd1;
                    if (r_nsp != '0) begin
                        n_nsp = r_nsp - FW'(1);
                    end else if (r_neg) begin
                        n_neg = 1'b0;
                    end else if (r_nz != '0) begin
                        n_nz = r_nz - FW'(1);
                    end else begin
                        n_ndig = w_dm1;
                    end
                    if (w_last) w_clr = 1'b1;
                end
            end
            S_SSET: begin
                n_nsp  = w_ssp;
                n_rem  = w_stot;
                n_sidx = '0;
                if (w_stot == 8'd0) w_clr = 1'b1;
            end
            S_SPAD: begin
                if (w_emit) begin
                    n_nsp = r_nsp - FW'(1);
                    n_rem = r_rem - 8'd1;
                    if (w_last) w_clr = 1'b1;
                end
            end
            S_SCHR: begin
                if (w_emit) begin
                    n_sidx = r_sidx + LW'(1);
                    n_rem  = r_rem - 8'd1;
                    if (w_last) w_clr = 1'b1;
                end
            end
            S_END: begin
                if (w_emit) begin
                    if (r_pct) begin
                        n_pct = 1'b0;
                    end else begin
                        w_clr    = 1'b1;
                        n_halted = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        if (w_clr) begin
            n_phase    = PH_TEXT;
            n_width    = '0;
            n_prec     = '0;
            n_prec_set = 1'b0;
            n_conv     = CV_NONE;
            n_slen     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_TEXT;
            r_conv     <= CV_NONE;
            r_width    <= '0;
            r_prec     <= '0;
            r_prec_set <= 1'b0;
            r_halted   <= 1'b0;
            r_pct      <= 1'b0;
            r_slen     <= '0;
            r_null     <= 1'b0;
            r_total    <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_conv     <= n_conv;
            r_width    <= n_width;
            r_prec     <= n_prec;
            r_prec_set <= n_prec_set;
            r_halted   <= n_halted;
            r_pct      <= n_pct;
            r_slen     <= n_slen;
            r_null     <= n_null;
            if (w_emit) begin
                if (w_is_cnt) begin
                    r_total <= '0;
                end else if (r_total != COUNT_MAX) begin
                    r_total <= r_total + CW'(1);
                end
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch   <= n_ch;
        r_sidx <= n_sidx;
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_nsp  <= n_nsp;
        r_nz   <= n_nz;
        r_ndig <= n_ndig;
        r_rem  <= n_rem;
        if (w_emit) begin
            r_ochar     <= w_char;
            r_ois_count <= w_is_cnt;
            r_ocount    <= w_is_cnt ? r_total : '0;
            r_olast     <= w_last;
        end
    end

    // string buffer
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_slen[SIW-1:0]] <= i_char_in;
        end
        r_rdata <= r_mem[r_sidx[SIW-1:0]];
    end

    a_count_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_count |-> o_last)
        else $error("count result without last");

    a_conv_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CONV |=> r_state == S_CONV || r_state == S_NSET)
        else $error("conversion left early");

    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEMIT || r_state == S_SPAD || r_state == S_SCHR) |-> r_rem != 8'd0)
        else $error("emitting with nothing remaining");

    a_slen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slen <= LW'(MAX_STRING))
        else $error("string length overflow");

    a_halt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> r_state == S_IDLE || r_state == S_END)
        else $error("halted block busy");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && !w_is_cnt && r_total != COUNT_MAX |=> r_total == $past(r_total) + CW'(1))
        else $error("character count not advanced");

endmodule

`default_nettype wire
